/* rtl/ppld_pkg.sv */
// ppld_pkg: shared constants, types and helpers for the landmark distance block
// depends on nothing
`default_nettype none
package ppld_pkg;
  localparam int NUM_TARGETS = 8;
  localparam int FRAC_BITS   = 16;
  localparam int NUM_MARKS   = 12;
  localparam int NUM_MEAS    = 7;
  localparam int CW          = 20;
  localparam int CFG_W       = 64;
  localparam int MW_W        = 12;
  localparam int IDX_W       = 3;
  localparam int MARK_W      = 4;
  localparam int SUM_W       = 44;
  localparam int ROOT_W      = 22;
  localparam int NUM_W       = 42;
  localparam int DEN_W       = 21;
  localparam int BND_W       = 30;
  localparam int PROD_W      = 52;

  localparam logic signed [CW:0] OFF_X = (CW+1)'(((20247 << FRAC_BITS) + 50000) / 100000);
  localparam logic signed [CW:0] OFF_Y = (CW+1)'(((161 << FRAC_BITS) + 50000) / 100000);
  localparam logic signed [CW:0] OFF_Z = (CW+1)'(((19 << FRAC_BITS) + 500) / 1000);
  localparam logic signed [21:0] FX_M = 22'sd1302729;
  localparam logic signed [21:0] CX_M = 22'sd921523;
  localparam logic signed [21:0] FY_M = 22'sd1302604;
  localparam logic signed [21:0] CY_M = 22'sd578403;
  localparam logic [CW-1:0] DIST_MAX = {CW{1'b1}};

  localparam logic [2:0] REG_WINDOW = 3'd0;
  localparam logic [2:0] REG_TGT_A  = 3'd1;
  localparam logic [2:0] REG_TGT_D  = 3'd4;

  typedef struct packed {
    logic start;      // latch point, begin projection
    logic mark_step;  // test one landmark window
    logic dist_start; // start one distance measure
    logic emit;       // load output register
  } ppld_cmd_t;

  typedef struct packed {
    logic proj_done;
    logic last_mark;
    logic dist_done;
    logic final_pt;
    logic zero_depth;
  } ppld_sts_t;

  function automatic logic [MARK_W-1:0] pair_a(input logic [IDX_W-1:0] m);
    case (m)
      3'd0: pair_a = 4'd0;
      3'd1: pair_a = 4'd2;
      3'd2: pair_a = 4'd4;
      3'd3: pair_a = 4'd5;
      3'd4: pair_a = 4'd7;
      3'd5: pair_a = 4'd7;
      default: pair_a = 4'd6;
    endcase
  endfunction

  function automatic logic [MARK_W-1:0] pair_b(input logic [IDX_W-1:0] m);
    case (m)
      3'd0: pair_b = 4'd1;
      3'd1: pair_b = 4'd3;
      3'd2: pair_b = 4'd8;
      3'd3: pair_b = 4'd9;
      3'd4: pair_b = 4'd10;
      3'd5: pair_b = 4'd11;
      default: pair_b = 4'd7;
    endcase
  endfunction
endpackage
`default_nettype wire

/* rtl/projected_point_landmark_distances.sv */
// projected_point_landmark_distances: top level, controller plus datapath
// depends on ppld_pkg, ppld_ctrl, ppld_dp
// One request is taken at a time. After the accepting cycle a point first goes through
// the projection products and the depth check; a point with zero shifted depth is then
// done unless it is final, while any other point tests its twelve landmark windows one
// per cycle. After a final point the seven distances follow, each as a sum of squares,
// a bit-serial square root of twenty-two steps, a load of the output register and the
// start of the next; a stalled output delays the next load.
`default_nettype none
module projected_point_landmark_distances (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [ppld_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [ppld_pkg::CW-1:0] point_x,
  input  wire logic signed [ppld_pkg::CW-1:0] point_y,
  input  wire logic signed [ppld_pkg::CW-1:0] point_z,
  input  wire logic                          final_point,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [ppld_pkg::IDX_W-1:0]         measure_index,
  output logic [ppld_pkg::CW-1:0]            distance,
  output logic                               last_measure
);
  import ppld_pkg::*;

  ppld_cmd_t cmd;
  ppld_sts_t sts;
  logic [MARK_W-1:0] mark;
  logic [IDX_W-1:0] meas;

  ppld_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
    .sts, .cmd, .mark, .meas
  );

  ppld_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .point_x, .point_y, .point_z, .final_point,
    .cmd, .mark, .meas, .out_stall, .out_valid, .sts,
    .measure_index, .distance, .last_measure
  );
endmodule
`default_nettype wire

/* rtl/ppld_ctrl.sv */
// ppld_ctrl: sequencer for projection, window tests and distance output
// depends on ppld_pkg
`default_nettype none
module ppld_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  input  wire ppld_pkg::ppld_sts_t     sts,
  output ppld_pkg::ppld_cmd_t          cmd,
  output logic [ppld_pkg::MARK_W-1:0]  mark,
  output logic [ppld_pkg::IDX_W-1:0]   meas
);
  import ppld_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PROJ = 5'b00010,
    S_MARK = 5'b00100,
    S_DIST = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [MARK_W-1:0] mark_next;
  logic [IDX_W-1:0] meas_next;
  logic out_valid_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    mark_next = mark;
    meas_next = meas;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_next = S_PROJ;
        end
      end
      S_PROJ: begin
        if (sts.proj_done) begin
          mark_next = '0;
          if (sts.zero_depth) begin
            if (sts.final_pt) begin
              meas_next = '0;
              state_next = S_DIST;
              cmd.dist_start = 1'b1;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            state_next = S_MARK;
          end
        end
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        mark_next = mark + 1'b1;
        if (sts.last_mark) begin
          if (sts.final_pt) begin
            meas_next = '0;
            state_next = S_DIST;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIST: begin
        if (sts.dist_done && !(out_valid && out_stall)) begin
          cmd.emit = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (meas == IDX_W'(NUM_MEAS - 1)) begin
          state_next = S_IDLE;
        end else begin
          meas_next = meas + 1'b1;
          cmd.dist_start = 1'b1;
          state_next = S_DIST;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_MARK && sts.last_mark && sts.final_pt) cmd.dist_start = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mark <= '0;
      meas <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      mark <= mark_next;
      meas <= meas_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

/* rtl/ppld_dp.sv */
// ppld_dp: projection numerators, window compares, landmark store and square root
// depends on ppld_pkg
`default_nettype none
module ppld_dp (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [ppld_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic signed [ppld_pkg::CW-1:0] point_x,
  input  wire logic signed [ppld_pkg::CW-1:0] point_y,
  input  wire logic signed [ppld_pkg::CW-1:0] point_z,
  input  wire logic                          final_point,
  input  wire ppld_pkg::ppld_cmd_t           cmd,
  input  wire logic [ppld_pkg::MARK_W-1:0]   mark,
  input  wire logic [ppld_pkg::IDX_W-1:0]    meas,
  input  wire logic                          out_stall,
  input  wire logic                          out_valid,
  output ppld_pkg::ppld_sts_t                sts,
  output logic [ppld_pkg::IDX_W-1:0]         measure_index,
  output logic [ppld_pkg::CW-1:0]            distance,
  output logic                               last_measure
);
  import ppld_pkg::*;

  logic [MW_W-1:0] match_window;
  logic [CFG_W-1:0] tregs [4];
  logic signed [CW-1:0] px, py, pz;
  logic fin;
  logic signed [CW:0] sx, sy, sz;
  logic signed [NUM_W-1:0] nu, nv;
  logic [DEN_W-1:0] den;
  logic [1:0] pstep;
  logic signed [43:0] prod_a, prod_b;
  logic signed [43:0] acc_u;
  logic signed [CW-1:0] lx [NUM_MARKS];
  logic signed [CW-1:0] ly [NUM_MARKS];
  logic signed [CW-1:0] lz [NUM_MARKS];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      match_window <= MW_W'(10);
      for (int i = 0; i < 4; i++) tregs[i] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW) match_window <= cfg_data[MW_W-1:0];
      else if (cfg_index >= REG_TGT_A && cfg_index <= REG_TGT_D)
        tregs[2'(cfg_index - REG_TGT_A)] <= cfg_data;
    end
  end

  function automatic logic [15:0] tu(input logic [2:0] n, input logic [CFG_W-1:0] r [4]);
    tu = n[0] ? r[n[2:1]][47:32] : r[n[2:1]][15:0];
  endfunction
  function automatic logic [15:0] tv(input logic [2:0] n, input logic [CFG_W-1:0] r [4]);
    tv = n[0] ? r[n[2:1]][63:48] : r[n[2:1]][31:16];
  endfunction

  // projection: two products per cycle, first for the u numerator, then for the v numerator
  always_comb begin
    case (pstep)
      2'd0: begin
        prod_a = 44'(FX_M * sx);
        prod_b = 44'(CX_M * sz);
      end
      default: begin
        prod_a = 44'(FY_M * sy);
        prod_b = 44'(CY_M * sz);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstep <= '0;
    end else if (cmd.start) begin
      pstep <= 2'd0;
    end else if (pstep != 2'd3) begin
      pstep <= pstep + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px <= point_x;
      py <= point_y;
      pz <= point_z;
      fin <= final_point;
      sx <= (CW+1)'(point_x) + OFF_X;
      sy <= (CW+1)'(point_y) - OFF_Y;
      sz <= (CW+1)'(point_z) - OFF_Z;
    end else if (pstep == 2'd0) begin
      acc_u <= prod_a + prod_b;
    end else if (pstep == 2'd1) begin
      if (sz < 0) begin
        nu <= NUM_W'(-acc_u);
        nv <= NUM_W'(-(prod_a + prod_b));
        den <= DEN_W'(-sz);
      end else begin
        nu <= NUM_W'(acc_u);
        nv <= NUM_W'(prod_a + prod_b);
        den <= DEN_W'(sz);
      end
    end
  end

  assign sts.proj_done  = (pstep == 2'd2);
  assign sts.zero_depth = (den == '0);
  assign sts.final_pt   = fin;
  assign sts.last_mark  = (mark == MARK_W'(NUM_MARKS - 1));

  // window test for the current landmark
  logic [15:0] cu, cv;
  always_comb begin
    case (mark)
      4'd8:  begin cu = tu(3'd4, tregs); cv = tv(3'd1, tregs); end
      4'd9:  begin cu = tu(3'd5, tregs); cv = tv(3'd1, tregs); end
      4'd10: begin cu = tu(3'd7, tregs); cv = tv(3'd1, tregs); end
      4'd11: begin cu = tu(3'd5, tregs); cv = tv(3'd7, tregs); end
      default: begin cu = tu(mark[2:0], tregs); cv = tv(mark[2:0], tregs); end
    endcase
  end

  logic signed [BND_W-1:0] lo_u, hi_u, lo_v, hi_v;
  logic signed [PROD_W-1:0] dens;
  logic hit;
  always_comb begin
    lo_u = (BND_W'($signed({1'b0, cu})) - BND_W'($signed({1'b0, match_window}))) * 1000;
    hi_u = (BND_W'($signed({1'b0, cu})) + BND_W'($signed({1'b0, match_window}))) * 1000;
    lo_v = (BND_W'($signed({1'b0, cv})) - BND_W'($signed({1'b0, match_window}))) * 1000;
    hi_v = (BND_W'($signed({1'b0, cv})) + BND_W'($signed({1'b0, match_window}))) * 1000;
    dens = PROD_W'($signed({1'b0, den}));
    hit = (PROD_W'(nu) >= PROD_W'(lo_u) * dens) && (PROD_W'(nu) <= PROD_W'(hi_u) * dens) &&
          (PROD_W'(nv) >= PROD_W'(lo_v) * dens) && (PROD_W'(nv) <= PROD_W'(hi_v) * dens);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MARKS; i++) begin
        lx[i] <= '0;
        ly[i] <= '0;
        lz[i] <= '0;
      end
    end else if (cmd.mark_step && hit) begin
      lx[mark] <= px;
      ly[mark] <= py;
      lz[mark] <= pz;
    end
  end

  // sum of squares over the three components, then bit-serial square root
  logic [MARK_W-1:0] ia, ib;
  logic [1:0] comp;
  logic signed [CW:0] diff;
  logic [CW:0] mag;
  logic [SUM_W-1:0] sum, rem;
  logic [ROOT_W-1:0] root;
  logic [4:0] rstep;
  logic sq_phase, busy;
  logic dist_done;
  logic [ROOT_W+1:0] trial;

  assign ia = pair_a(meas);
  assign ib = pair_b(meas);
  assign sts.dist_done = dist_done;

  always_comb begin
    case (comp)
      2'd0: diff = (CW+1)'(lx[ia]) - (CW+1)'(lx[ib]);
      2'd1: diff = (CW+1)'(ly[ia]) - (CW+1)'(ly[ib]);
      default: diff = (CW+1)'(lz[ia]) - (CW+1)'(lz[ib]);
    endcase
    mag = diff[CW] ? (CW+1)'(-diff) : (CW+1)'(diff);
    trial = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      dist_done <= 1'b0;
    end else if (cmd.dist_start) begin
      busy <= 1'b1;
      sq_phase <= 1'b1;
      comp <= '0;
      sum <= '0;
      dist_done <= 1'b0;
    end else if (busy) begin
      if (sq_phase) begin
        sum <= sum + SUM_W'(mag * mag);
        if (comp == 2'd2) begin
          sq_phase <= 1'b0;
          rstep <= 5'(ROOT_W - 1);
          root <= '0;
          rem <= '0;
        end
        comp <= comp + 1'b1;
      end else begin
        if ({rem[SUM_W-3:0], sum[SUM_W-1 -: 2]} >= SUM_W'(trial)) begin
          rem <= {rem[SUM_W-3:0], sum[SUM_W-1 -: 2]} - SUM_W'(trial);
          root <= {root[ROOT_W-2:0], 1'b1};
        end else begin
          rem <= {rem[SUM_W-3:0], sum[SUM_W-1 -: 2]};
          root <= {root[ROOT_W-2:0], 1'b0};
        end
        sum <= {sum[SUM_W-3:0], 2'b00};
        if (rstep == '0) begin
          busy <= 1'b0;
          dist_done <= 1'b1;
        end
        rstep <= rstep - 1'b1;
      end
    end else if (cmd.emit) begin
      dist_done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      measure_index <= meas;
      distance <= (root > ROOT_W'(DIST_MAX)) ? DIST_MAX : root[CW-1:0];
      last_measure <= (meas == IDX_W'(NUM_MEAS - 1));
    end else if (!(out_valid && out_stall) && rst) begin
      last_measure <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* rtl/ppld_checker.sv */
// ppld_checker: port-level checks for the landmark distance block
// depends on the top level ports, bound below
`default_nettype none
module ppld_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic [2:0] measure_index,
  input wire logic last_measure
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(measure_index)) else $error("out hold");
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_measure |-> measure_index == 3'd6) else $error("last index");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> measure_index != 3'd7) else $error("index range");
  a_no_take: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_measure |-> in_stall) else $error("request during output");
endmodule

bind projected_point_landmark_distances ppld_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .measure_index, .last_measure
);
`default_nettype wire
